@@ design/json_byte_tokenizer_unit_macros.svh @@
// assertion macros for the json byte tokenizer
`ifndef JSON_BYTE_TOKENIZER_UNIT_MACROS_SVH
`define JSON_BYTE_TOKENIZER_UNIT_MACROS_SVH

`ifndef SYNTH
// checked outside reset
`define JBT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("json tokenizer check failed");
// checked at every edge, reset included
`define JBT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("json tokenizer check failed");
`else
`define JBT_ASSERT(lbl, clk, rstn, prop)
`define JBT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ design/jbt_pkg.sv @@
package jbt_pkg;

    localparam int STRING_LIMIT = 4096;
    localparam int LEN_W        = $clog2(STRING_LIMIT);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(STRING_LIMIT - 1);

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;

    localparam logic [2:0] SKIP_NT = 3'd3;
    localparam logic [2:0] SKIP_F  = 3'd4;

    typedef enum logic [2:0] {
        M_IDLE = 3'd0,
        M_STR  = 3'd1,
        M_ESC  = 3'd2,
        M_INT  = 3'd3,
        M_FRAC = 3'd4,
        M_SKIP = 3'd5
    } t_mode;

    typedef enum logic [3:0] {
        K_LBRACE   = 4'd0,
        K_RBRACE   = 4'd1,
        K_LBRACK   = 4'd2,
        K_RBRACK   = 4'd3,
        K_COLON    = 4'd4,
        K_COMMA    = 4'd5,
        K_STRSTART = 4'd6,
        K_STRCHAR  = 4'd7,
        K_STREND   = 4'd8,
        K_NUMBER   = 4'd9,
        K_NULL     = 4'd10,
        K_TRUE     = 4'd11,
        K_FALSE    = 4'd12,
        K_END      = 4'd13
    } t_kind;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_in;

    typedef struct packed {
        t_kind              token_kind;
        logic [7:0]         char_value;
        logic signed [63:0] number_value;
        logic               last_of_run;
    } t_out;

endpackage

@@ design/json_byte_tokenizer_unit.sv @@
// channel | dir | handshake                 | payload
// input   | in  | i_in_valid / o_in_ready   | i_in  (t_in, one text byte)
// output  | out | o_out_valid / i_out_ready | o_out (t_out, one token)
// a byte yields 0 to 3 tokens and sits in the input register until its last token is loaded;
// a byte with no token retires in the cycle after acceptance
// unless stalled, output takes one token a cycle; one-token bytes run at one per cycle
// reset is synchronous and returns the lexer to between-token state
// a stalled output holds its token and the input register; the input stalls behind it
`include "json_byte_tokenizer_unit_macros.svh"

module json_byte_tokenizer_unit
    import jbt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    logic             r_in_v;
    t_in              r_in;
    logic [1:0]       r_idx;
    logic             r_out_v;
    t_out             r_out;
    t_mode            r_mode;
    logic [2:0]       r_skip;
    logic [63:0]      r_acc;
    logic             r_neg;
    logic [LEN_W-1:0] r_len;

    t_mode            n_mode;
    logic [2:0]       n_skip;
    logic [63:0]      n_acc;
    logic             n_neg;
    logic [LEN_W-1:0] n_len;

    t_kind       tk_kind [4];
    logic [7:0]  tk_char [4];
    logic [63:0] tk_num  [4];
    logic [1:0]  cnt;

    logic load;
    logic done;

    always_comb begin
        logic [7:0]  b;
        logic        fin;
        logic        digit;
        logic [7:0]  esc_ch;
        logic [2:0]  sk;
        logic        idle_tok;
        t_kind       idle_kind;
        t_mode       idle_mode;
        logic [2:0]  idle_skip;
        logic [63:0] idle_acc;
        logic        idle_neg;
        logic        idle_clr_len;
        logic        use_idle;

        b      = r_in.text_byte;
        fin    = r_in.final_byte;
        digit  = (b >= CH_0) && (b <= CH_9);
        esc_ch = (b == CH_N) ? CH_LF : ((b == CH_T) ? CH_TAB : b);
        sk     = (r_skip != 3'd0) ? r_skip - 3'd1 : 3'd0;

        // between-token decode of the current byte
        idle_tok     = 1'b0;
        idle_kind    = K_NUMBER;
        idle_mode    = M_IDLE;
        idle_skip    = r_skip;
        idle_acc     = r_acc;
        idle_neg     = r_neg;
        idle_clr_len = 1'b0;
        priority if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR) begin
            idle_tok = 1'b0;
        end else if (b == CH_LBRACE) begin
            idle_tok  = 1'b1;
            idle_kind = K_LBRACE;
        end else if (b == CH_RBRACE) begin
            idle_tok  = 1'b1;
            idle_kind = K_RBRACE;
        end else if (b == CH_LBRACK) begin
            idle_tok  = 1'b1;
            idle_kind = K_LBRACK;
        end else if (b == CH_RBRACK) begin
            idle_tok  = 1'b1;
            idle_kind = K_RBRACK;
        end else if (b == CH_COLON) begin
            idle_tok  = 1'b1;
            idle_kind = K_COLON;
        end else if (b == CH_COMMA) begin
            idle_tok  = 1'b1;
            idle_kind = K_COMMA;
        end else if (b == CH_QUOTE) begin
            idle_tok     = 1'b1;
            idle_kind    = K_STRSTART;
            idle_mode    = M_STR;
            idle_clr_len = 1'b1;
        end else if (b == CH_N) begin
            idle_tok  = 1'b1;
            idle_kind = K_NULL;
            idle_mode = M_SKIP;
            idle_skip = SKIP_NT;
        end else if (b == CH_T) begin
            idle_tok  = 1'b1;
            idle_kind = K_TRUE;
            idle_mode = M_SKIP;
            idle_skip = SKIP_NT;
        end else if (b == CH_F) begin
            idle_tok  = 1'b1;
            idle_kind = K_FALSE;
            idle_mode = M_SKIP;
            idle_skip = SKIP_F;
        end else if (b == CH_MINUS) begin
            idle_neg  = 1'b1;
            idle_acc  = 64'd0;
            idle_mode = M_INT;
        end else if (b == CH_DOT) begin
            idle_neg  = 1'b0;
            idle_acc  = 64'd0;
            idle_mode = M_FRAC;
        end else if (digit) begin
            idle_neg  = 1'b0;
            idle_acc  = 64'(b - CH_0);
            idle_mode = M_INT;
        end else begin
            idle_tok  = 1'b1;
            idle_kind = K_NUMBER;
        end

        n_mode = r_mode;
        n_skip = r_skip;
        n_acc  = r_acc;
        n_neg  = r_neg;
        n_len  = r_len;
        cnt    = 2'd0;
        for (int i = 0; i < 4; i++) begin
            tk_kind[i] = K_END;
            tk_char[i] = 8'd0;
            tk_num[i]  = 64'd0;
        end
        use_idle = 1'b0;

        unique case (r_mode)
            M_STR: begin
                if (b == CH_QUOTE) begin
                    tk_kind[0] = K_STREND;
                    cnt        = 2'd1;
                    n_mode     = M_IDLE;
                end else if (b == CH_BSLASH && !fin) begin
                    n_mode = M_ESC;
                end else if (r_len < LEN_MAX) begin
                    n_len      = r_len + LEN_W'(1);
                    tk_kind[0] = K_STRCHAR;
                    tk_char[0] = b;
                    cnt        = 2'd1;
                end
            end
            M_ESC: begin
                n_mode = M_STR;
                if (r_len < LEN_MAX) begin
                    n_len      = r_len + LEN_W'(1);
                    tk_kind[0] = K_STRCHAR;
                    tk_char[0] = esc_ch;
                    cnt        = 2'd1;
                end
            end
            M_INT: begin
                if (digit) begin
                    n_acc = (r_acc << 3) + (r_acc << 1) + 64'(b - CH_0);
                end else if (b == CH_DOT) begin
                    n_mode = M_FRAC;
                end else begin
                    tk_kind[0] = K_NUMBER;
                    tk_num[0]  = r_neg ? (64'd0 - r_acc) : r_acc;
                    cnt        = 2'd1;
                    use_idle   = 1'b1;
                end
            end
            M_FRAC: begin
                if (!digit) begin
                    tk_kind[0] = K_NUMBER;
                    tk_num[0]  = r_neg ? (64'd0 - r_acc) : r_acc;
                    cnt        = 2'd1;
                    use_idle   = 1'b1;
                end
            end
            M_SKIP: begin
                n_skip = sk;
                if (sk == 3'd0) begin
                    n_mode = M_IDLE;
                end
            end
            default: begin
                use_idle = 1'b1;
            end
        endcase

        if (use_idle) begin
            n_mode = idle_mode;
            n_skip = idle_skip;
            n_acc  = idle_acc;
            n_neg  = idle_neg;
            if (idle_clr_len) begin
                n_len = '0;
            end
            if (idle_tok) begin
                tk_kind[cnt] = idle_kind;
                cnt          = cnt + 2'd1;
            end
        end

        // end of text: flush open string or number, then the end token if there is room
        if (fin) begin
            if (n_mode == M_STR || n_mode == M_ESC) begin
                tk_kind[cnt] = K_STREND;
                cnt          = cnt + 2'd1;
            end else if (n_mode == M_INT || n_mode == M_FRAC) begin
                tk_kind[cnt] = K_NUMBER;
                tk_num[cnt]  = n_neg ? (64'd0 - n_acc) : n_acc;
                cnt          = cnt + 2'd1;
            end
            if (cnt != 2'd3) begin
                tk_kind[cnt] = K_END;
                cnt          = cnt + 2'd1;
            end
            n_mode = M_IDLE;
            n_skip = 3'd0;
            n_acc  = 64'd0;
            n_neg  = 1'b0;
            n_len  = '0;
        end
    end

    assign load = r_in_v && (cnt != 2'd0) && (!r_out_v || i_out_ready);
    assign done = r_in_v && ((cnt == 2'd0) || (load && (r_idx == cnt - 2'd1)));

    assign o_in_ready  = !r_in_v || done;
    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_idx   <= 2'd0;
            r_out_v <= 1'b0;
            r_mode  <= M_IDLE;
            r_skip  <= 3'd0;
            r_acc   <= 64'd0;
            r_neg   <= 1'b0;
            r_len   <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_v <= i_in_valid;
            end
            if (done) begin
                r_idx  <= 2'd0;
                r_mode <= n_mode;
                r_skip <= n_skip;
                r_acc  <= n_acc;
                r_neg  <= n_neg;
                r_len  <= n_len;
            end else if (load) begin
                r_idx <= r_idx + 2'd1;
            end
            if (load) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (load) begin
            r_out.token_kind   <= tk_kind[r_idx];
            r_out.char_value   <= tk_char[r_idx];
            r_out.number_value <= $signed(tk_num[r_idx]);
            r_out.last_of_run  <= (r_idx == cnt - 2'd1);
        end
    end

    `JBT_ASSERT_ALWAYS(a_reset_clears, i_clk,
        !i_rst_n |=> !o_out_valid && !r_in_v && r_idx == 2'd0)
    `JBT_ASSERT(a_end_is_last, i_clk, i_rst_n,
        o_out_valid && o_out.token_kind == K_END |-> o_out.last_of_run)
    `JBT_ASSERT(a_final_resets_state, i_clk, i_rst_n,
        done && r_in.final_byte |=> r_mode == M_IDLE && r_len == '0 && r_skip == 3'd0)
    `JBT_ASSERT(a_idx_in_run, i_clk, i_rst_n, r_in_v && r_idx != 2'd0 |-> r_idx < cnt)

endmodule

@@ verif/json_byte_tokenizer_unit_tb.sv @@
`timescale 1ns / 1ps

module json_byte_tokenizer_unit_tb;
    import jbt_pkg::*;

    localparam int MAX_TOKENS_PER_BYTE = 3;

    typedef logic [7:0] t_bytes[$];

    class token_scoreboard;
        t_mode             mode;
        logic [2:0]        skip_left;
        logic [63:0]       acc;
        logic              neg;
        logic [LEN_W-1:0]  str_len;
        t_out              step_tokens[$];
        t_out              pending_tokens[$];
        int                errors;

        function new();
            clear_state();
            errors = 0;
        endfunction

        function void clear_state();
            mode      = M_IDLE;
            skip_left = '0;
            acc       = '0;
            neg       = 1'b0;
            str_len   = '0;
        endfunction

        function void add_token(t_kind k, logic [7:0] c = 8'd0, logic [63:0] v = 64'd0);
            t_out t;
            if (step_tokens.size() < MAX_TOKENS_PER_BYTE) begin
                t.token_kind   = k;
                t.char_value   = c;
                t.number_value = v;
                t.last_of_run  = 1'b0;
                step_tokens.push_back(t);
            end
        endfunction

        function void add_number();
            add_token(K_NUMBER, 8'd0, neg ? 64'd0 - acc : acc);
        endfunction

        // characters past the string cap are dropped
        function void add_char(logic [7:0] c);
            if (str_len < LEN_MAX) begin
                str_len++;
                add_token(K_STRCHAR, c);
            end
        endfunction

        function void start_token(logic [7:0] b);
            mode = M_IDLE;
            case (b)
                CH_SPACE, CH_TAB, CH_LF, CH_CR: ;
                CH_LBRACE: add_token(K_LBRACE);
                CH_RBRACE: add_token(K_RBRACE);
                CH_LBRACK: add_token(K_LBRACK);
                CH_RBRACK: add_token(K_RBRACK);
                CH_COLON:  add_token(K_COLON);
                CH_COMMA:  add_token(K_COMMA);
                CH_QUOTE: begin
                    add_token(K_STRSTART);
                    str_len = '0;
                    mode    = M_STR;
                end
                CH_N: begin
                    add_token(K_NULL);
                    skip_left = SKIP_NT;
                    mode      = M_SKIP;
                end
                CH_T: begin
                    add_token(K_TRUE);
                    skip_left = SKIP_NT;
                    mode      = M_SKIP;
                end
                CH_F: begin
                    add_token(K_FALSE);
                    skip_left = SKIP_F;
                    mode      = M_SKIP;
                end
                CH_MINUS: begin
                    neg  = 1'b1;
                    acc  = '0;
                    mode = M_INT;
                end
                CH_DOT: begin
                    neg  = 1'b0;
                    acc  = '0;
                    mode = M_FRAC;
                end
                default: begin
                    if (b >= CH_0 && b <= CH_9) begin
                        neg  = 1'b0;
                        acc  = 64'(b - CH_0);
                        mode = M_INT;
                    end else begin
                        add_token(K_NUMBER);
                    end
                end
            endcase
        endfunction

        function void note_byte(t_in x);
            logic [7:0] b;
            logic       fin;
            logic       digit;
            b     = x.text_byte;
            fin   = x.final_byte;
            digit = (b >= CH_0) && (b <= CH_9);
            step_tokens.delete();
            case (mode)
                M_STR: begin
                    if (b == CH_QUOTE) begin
                        add_token(K_STREND);
                        mode = M_IDLE;
                    end else if (b == CH_BSLASH && !fin) begin
                        mode = M_ESC;
                    end else begin
                        add_char(b);
                    end
                end
                M_ESC: begin
                    add_char(b == CH_N ? CH_LF : (b == CH_T ? CH_TAB : b));
                    mode = M_STR;
                end
                M_INT: begin
                    if (digit) begin
                        acc = acc * 64'd10 + 64'(b - CH_0);
                    end else if (b == CH_DOT) begin
                        mode = M_FRAC;
                    end else begin
                        add_number();
                        start_token(b);
                    end
                end
                M_FRAC: begin
                    if (!digit) begin
                        add_number();
                        start_token(b);
                    end
                end
                M_SKIP: begin
                    if (skip_left != 0) skip_left--;
                    if (skip_left == 0) mode = M_IDLE;
                end
                default: start_token(b);
            endcase
            if (fin) begin
                if (mode == M_STR || mode == M_ESC) add_token(K_STREND);
                else if (mode == M_INT || mode == M_FRAC) add_number();
                add_token(K_END);
                clear_state();
            end
            if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
            foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_token(t_out got);
            t_out want;
            if (pending_tokens.size() == 0) begin
                $display("%0t: token kind %0d with none expected", $time, got.token_kind);
                errors++;
            end else begin
                want = pending_tokens.pop_front();
                compare("token_kind", want.token_kind, got.token_kind);
                compare("char_value", want.char_value, got.char_value);
                compare("number_value", want.number_value, got.number_value);
                compare("last_of_run", want.last_of_run, got.last_of_run);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_in  i_in        = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out;

    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int idle_plan[4]  = '{0, 51, 0, 8};
    int stall_plan[4] = '{0, 0, 51, 8};

    token_scoreboard sb;

    json_byte_tokenizer_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_byte(i_in);
            if (o_out_valid && i_out_ready) sb.check_token(o_out);
        end
    end

    function automatic void push_str(ref t_bytes q, input string s);
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] string_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    function automatic void add_value(ref t_bytes q);
        logic [7:0] punct [6] = '{CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK,
                                  CH_COLON, CH_COMMA};
        logic [7:0] blank [4] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
        logic [7:0] escaped [4] = '{CH_N, CH_T, CH_QUOTE, CH_BSLASH};
        int n;
        case ($urandom_range(7))
            0: q.push_back(punct[$urandom_range(5)]);
            1: repeat ($urandom_range(1, 3)) q.push_back(blank[$urandom_range(3)]);
            2, 3: begin
                q.push_back(CH_QUOTE);
                repeat ($urandom_range(8)) begin
                    if ($urandom_range(3) == 0) begin
                        q.push_back(CH_BSLASH);
                        n = $urandom_range(4);
                        q.push_back(n < 4 ? escaped[n] : string_byte());
                    end else begin
                        q.push_back(string_byte());
                    end
                end
                q.push_back(CH_QUOTE);
            end
            4, 5: begin
                if ($urandom_range(1) == 1) q.push_back(CH_MINUS);
                // long runs of digits wrap the 64-bit value
                n = ($urandom_range(5) == 0) ? $urandom_range(15, 24) : $urandom_range(1, 4);
                repeat (n) q.push_back(CH_0 + 8'($urandom_range(9)));
                if ($urandom_range(2) == 0) begin
                    q.push_back(CH_DOT);
                    repeat ($urandom_range(3)) q.push_back(CH_0 + 8'($urandom_range(9)));
                end
            end
            6: begin
                case ($urandom_range(2))
                    0: push_str(q, "null");
                    1: push_str(q, "true");
                    default: push_str(q, "false");
                endcase
            end
            default: q.push_back(8'($urandom_range(255)));
        endcase
    endfunction

    // mostly well-formed text, some cut short, some noise
    function automatic void build_doc(ref t_bytes q);
        int r;
        int cut;
        q.delete();
        r = $urandom_range(99);
        if (r < 15) begin
            repeat ($urandom_range(1, 12)) q.push_back(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(1, 10)) add_value(q);
            if (r < 30 && q.size() > 1) begin
                cut = $urandom_range(1, q.size() - 1);
                while (q.size() > cut) void'(q.pop_back());
            end
        end
        if (q.size() == 0) q.push_back(CH_COMMA);
    endfunction

    task automatic send_doc(input t_bytes q);
        t_in x;
        foreach (q[i]) begin
            x.text_byte  = q[i];
            x.final_byte = (i == q.size() - 1);
            while ($urandom_range(99) < in_idle_pct) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in       <= x;
            do @(posedge i_clk); while (!o_in_ready);
        end
    endtask

    initial begin
        t_bytes doc;
        int     sent;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // punctuation, whitespace, escapes, fraction, lone dot and minus, other bytes
        doc.delete();
        push_str(doc, "{[]}:,");
        doc.push_back(CH_CR);
        push_str(doc, "\"\\n\\t\\q\"-7.5\t.- ");
        doc.push_back(8'h00);
        doc.push_back(CH_N);
        send_doc(doc);
        doc.delete();
        doc.push_back(CH_T);
        send_doc(doc);
        doc.delete();
        doc.push_back(CH_F);
        doc.push_back(8'hFF);
        send_doc(doc);
        // closing quote on a number at the end of text
        doc.delete();
        push_str(doc, "-5\"");
        send_doc(doc);
        // backslash as the last byte
        doc.delete();
        push_str(doc, "\"\\");
        send_doc(doc);

        // string running past the cap, escapes included
        doc.delete();
        doc.push_back(CH_QUOTE);
        repeat (LEN_MAX - 1) doc.push_back(string_byte());
        push_str(doc, "\\na\\t\",");
        send_doc(doc);

        for (int p = 0; p < 4; p++) begin
            in_idle_pct   = idle_plan[p];
            out_stall_pct = stall_plan[p];
            sent = 0;
            while (sent < 100) begin
                build_doc(doc);
                send_doc(doc);
                sent += doc.size();
            end
        end
        i_in_valid <= 1'b0;

        do @(posedge i_clk); while (sb.pending_tokens.size() != 0);
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
